// File: sv/wfdr_pkg.sv
// Shared types and constants of the word frame deframer.
// Used by wfdr_cell and by the top level word_frame_deframer_resync.
`timescale 1ns / 1ps
`default_nettype none
package wfdr_pkg;

    localparam int HEADER_WORDS = 8;
    localparam int HIT_WORDS    = 6;
    localparam int MAX_FRAME    = 64;

    localparam logic [2:0] CFG_MAGIC_WORD     = 3'd0;
    localparam logic [2:0] CFG_END_WORD       = 3'd1;
    localparam logic [2:0] CFG_FORMAT_VERSION = 3'd2;
    localparam logic [2:0] CFG_MAP_FLAG_MASK  = 3'd3;
    localparam logic [2:0] CFG_MAX_RANGE      = 3'd4;
    localparam logic [2:0] CFG_MAX_DOPPLER    = 3'd5;
    localparam logic [2:0] CFG_MAX_HIT_COUNT  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_LEN,
        S_EMIT,
        S_DROP,
        S_SEEK
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/wfdr_cell.sv
// One buffer cell of the deframer: a word and its end-word match at the frame tail.
// Depends on wfdr_pkg for the control struct and the frame size limit.
`timescale 1ns / 1ps
`default_nettype none
module wfdr_cell #(
    parameter int INDEX = 0,
    parameter int FW    = 7
) (
    input  wire                      clk,
    input  wfdr_pkg::cell_ctrl_t     ctrl,
    input  wire  [FW-1:0]            wr_idx,
    input  wire  [31:0]              wr_word,
    input  wire  [31:0]              nb_word,
    input  wire  [6:0]               tail,
    input  wire  [31:0]              end_word,
    output logic [31:0]              word,
    output logic                     tail_hit
);
    import wfdr_pkg::*;

    localparam logic [FW-1:0] MY_IDX = FW'(INDEX);
    localparam bit            REACH  = (INDEX < MAX_FRAME);
    localparam logic [6:0]    TAIL_IDX = 7'(INDEX);

    logic [31:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            word_reg <= nb_word;
        end
        else if (ctrl.load && (wr_idx == MY_IDX))
        begin
            word_reg <= wr_word;
        end
    end

    assign word     = word_reg;
    assign tail_hit = REACH && (tail == TAIL_IDX) && (word_reg == end_word);

endmodule
`default_nettype wire

// File: sv/word_frame_deframer_resync.sv
// Top level of the word frame deframer with resynchronization.
// Depends on wfdr_pkg and a row of wfdr_cell instances.
//
// Channel  Direction  Content
// s_axis   in         tdata[31:0] word
// m_axis   out        tdata[31:0] frame_word, [37:32] word_position; tlast last_word
// cfg      in         write enable, register index, 32-bit data
//
// A word that extends the buffer passes S_IDLE and S_EVAL; a header parse adds S_MUL, S_LEN and S_EVAL.
// A valid frame leaves one word per cycle from cell zero while m_tready is high.
// A bad frame loses its first word in S_DROP; S_SEEK then skips words until a magic word or an empty buffer.
// Reset empties the buffer at once; cell contents stay undefined until written.
// Output stalls hold the frame in place; no input is taken until it has left.
`timescale 1ns / 1ps
`default_nettype none
module word_frame_deframer_resync #(
    parameter int BUFFER_WORDS = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,     // word
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,     // frame_word, word_position, zero fill
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    import wfdr_pkg::*;

    localparam int FW      = $clog2(BUFFER_WORDS + 1);
    localparam int CW      = (FW > 7) ? FW : 7;
    localparam int LEN_MAX = (BUFFER_WORDS < MAX_FRAME) ? BUFFER_WORDS : MAX_FRAME;

    logic [31:0] magic_reg;
    logic [31:0] end_word_reg;
    logic [15:0] version_reg;
    logic [15:0] mask_reg;
    logic [6:0]  max_range_reg;
    logic [6:0]  max_dop_reg;
    logic [6:0]  hit_cap_reg;

    state_t      state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [6:0]  len_reg, len_next;
    logic [5:0]  pos_reg, pos_next;
    logic        ok_reg;
    logic        map_reg;
    logic [9:0]  nh6_reg;
    logic [13:0] rd_reg;

    cell_ctrl_t  ctrl;
    logic [31:0] cell_word [BUFFER_WORDS];
    logic [BUFFER_WORDS-1:0] hits;
    logic [6:0]  tail;
    logic        end_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg     <= '0;
            end_word_reg  <= '0;
            version_reg   <= 16'd1;
            mask_reg      <= 16'd1;
            max_range_reg <= 7'd64;
            max_dop_reg   <= 7'd64;
            hit_cap_reg   <= 7'd9;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAGIC_WORD:     magic_reg     <= cfg_data;
                CFG_END_WORD:       end_word_reg  <= cfg_data;
                CFG_FORMAT_VERSION: version_reg   <= cfg_data[15:0];
                CFG_MAP_FLAG_MASK:  mask_reg      <= cfg_data[15:0];
                CFG_MAX_RANGE:      max_range_reg <= cfg_data[6:0];
                CFG_MAX_DOPPLER:    max_dop_reg   <= cfg_data[6:0];
                CFG_MAX_HIT_COUNT:  hit_cap_reg   <= cfg_data[6:0];
                default:            ;
            endcase
        end
    end

    assign tail = len_reg - 7'd1;

    genvar gi;
    generate
        for (gi = 0; gi < BUFFER_WORDS; gi++)
        begin : g_cell
            logic [31:0] nb_w;
            if (gi == BUFFER_WORDS - 1)
            begin : g_end
                assign nb_w = '0;
            end
            else
            begin : g_mid
                assign nb_w = cell_word[gi+1];
            end
            wfdr_cell #(
                .INDEX (gi),
                .FW    (FW)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .wr_idx   (fill_reg),
                .wr_word  (s_tdata),
                .nb_word  (nb_w),
                .tail     (tail),
                .end_word (end_word_reg),
                .word     (cell_word[gi]),
                .tail_hit (hits[gi])
            );
        end
    endgenerate

    assign end_hit = |hits;

    logic [15:0] nr, nd, nh;
    logic        map_now, ok_now;
    logic [14:0] len_sum;

    assign nr      = cell_word[3][31:16];
    assign nd      = cell_word[3][15:0];
    assign nh      = cell_word[4][31:16];
    assign map_now = (cell_word[1][15:0] & mask_reg) != 16'd0;
    assign ok_now  = (cell_word[1][31:16] == version_reg)
                  && (nh <= {9'd0, hit_cap_reg})
                  && (!map_now || ((nr != 16'd0) && (nd != 16'd0)
                                   && (nr <= {9'd0, max_range_reg})
                                   && (nd <= {9'd0, max_dop_reg})));
    assign len_sum = 15'(HEADER_WORDS + 1) + {5'd0, nh6_reg}
                   + (map_reg ? {1'b0, rd_reg} : 15'd0);

    always_ff @(posedge clk)
    begin
        ok_reg  <= ok_now;
        map_reg <= map_now;
        nh6_reg <= 10'(nh[6:0] * 3'(HIT_WORDS));
        rd_reg  <= nr[6:0] * nd[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

    logic last_now;
    assign last_now = ({1'b0, pos_reg} + 7'd1) == len_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && !((fill_reg == '0) && (s_tdata != magic_reg)))
                begin
                    ctrl.load  = 1'b1;
                    fill_next  = fill_reg + FW'(1);
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (fill_reg < FW'(HEADER_WORDS))
                begin
                    state_next = S_IDLE;
                end
                else if (len_reg == 7'd0)
                begin
                    state_next = S_MUL;
                end
                else if (CW'(fill_reg) < CW'(len_reg))
                begin
                    state_next = S_IDLE;
                end
                else if (!end_hit)
                begin
                    state_next = S_DROP;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                state_next = S_LEN;
            end
            S_LEN:
            begin
                if (!ok_reg || (len_sum > 15'(LEN_MAX)))
                begin
                    state_next = S_DROP;
                end
                else
                begin
                    len_next   = len_sum[6:0];
                    state_next = S_EVAL;
                end
            end
            S_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - FW'(1);
                    pos_next   = pos_reg + 6'd1;
                    if (last_now)
                    begin
                        len_next   = '0;
                        state_next = S_EVAL;
                    end
                end
            end
            S_DROP:
            begin
                ctrl.shift = 1'b1;
                fill_next  = fill_reg - FW'(1);
                len_next   = '0;
                state_next = S_SEEK;
            end
            S_SEEK:
            begin
                if (fill_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (cell_word[0] == magic_reg)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - FW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tdata = {2'b00, pos_reg, cell_word[0]};
    assign m_tlast = last_now;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(fill_reg) <= CW'(BUFFER_WORDS))
        else $error("buffer fill beyond its depth");
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (fill_reg != '0) && (len_reg != 7'd0))
        else $error("frame word offered from an empty buffer");
    a_idle_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && len_reg != 7'd0) |-> CW'(fill_reg) < CW'(len_reg))
        else $error("waiting for input while a frame is complete");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (len_reg == 7'd0))
        else $error("frame length kept after the end word left");

endmodule
`default_nettype wire

// File: dv/word_frame_deframer_resync_tb.sv
// Self-checking testbench for word_frame_deframer_resync: drives word streams
// of good and broken frames, predicts the emitted frames and compares them.
// Depends on wfdr_pkg and the word_frame_deframer_resync RTL.
`timescale 1ns / 1ps
module word_frame_deframer_resync_tb;
    import wfdr_pkg::*;

    localparam int BUF_WORDS   = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 300;

    typedef struct {
        logic [31:0] word;
        logic [5:0]  pos;
        logic        last;
    } frame_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    frame_word_t frame_words_due[$];
    logic [31:0] fbuf [BUF_WORDS];
    int unsigned fill;
    int unsigned frame_len;
    logic [31:0] magic, end_w;
    logic [15:0] version, map_mask;
    logic [6:0]  max_range, max_doppler, hit_cap;

    int          send_idle_pct;
    int          stall_pct;
    int          errors;
    int          cycles;
    int          sent;

    word_frame_deframer_resync u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        frame_word_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_words_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected frame word %h pos %0d last %b",
                             m_tdata[31:0], m_tdata[37:32], m_tlast);
            end
            else
            begin
                e = frame_words_due.pop_front();
                if (m_tdata[31:0] !== e.word || m_tdata[37:32] !== e.pos
                    || m_tlast !== e.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: expected %h/%0d/%b got %h/%0d/%b",
                                 e.word, e.pos, e.last,
                                 m_tdata[31:0], m_tdata[37:32], m_tlast);
                end
            end
        end
    end

    function automatic bit has_map();
        return ((fbuf[1][15:0] & map_mask) != 16'd0);
    endfunction

    function automatic bit header_good();
        logic [15:0] nr, nd, nh;
        nr = fbuf[3][31:16];
        nd = fbuf[3][15:0];
        nh = fbuf[4][31:16];
        if (fbuf[1][31:16] != version) return 1'b0;
        if (nh > hit_cap) return 1'b0;
        if (has_map())
        begin
            if (nr == 0 || nd == 0) return 1'b0;
            if (nr > max_range || nd > max_doppler) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic resync();
        int unsigned j;
        j = 1;
        while (j < fill && fbuf[j] != magic) j++;
        if (j < fill)
        begin
            for (int unsigned k = 0; k < fill - j; k++) fbuf[k] = fbuf[k + j];
            fill = fill - j;
        end
        else
            fill = 0;
        frame_len = 0;
    endtask

    task automatic emit_frames(inout int unsigned n, output bit held);
        int unsigned len;
        frame_word_t fw;
        held = 1'b0;
        forever
        begin
            if (fill < HEADER_WORDS) return;
            if (frame_len == 0)
            begin
                if (!header_good())
                begin
                    resync();
                    continue;
                end
                len = HEADER_WORDS + 1 + fbuf[4][31:16] * HIT_WORDS;
                if (has_map()) len += fbuf[3][31:16] * fbuf[3][15:0];
                if (len > BUF_WORDS || len > MAX_FRAME)
                begin
                    resync();
                    continue;
                end
                frame_len = len;
            end
            if (fill < frame_len) return;
            if (fbuf[frame_len - 1] != end_w)
            begin
                resync();
                continue;
            end
            if (n + frame_len > MAX_FRAME)
            begin
                held = 1'b1;
                return;
            end
            for (int unsigned i = 0; i < frame_len; i++)
            begin
                fw.word = fbuf[i];
                fw.pos  = i[5:0];
                fw.last = (i == frame_len - 1);
                frame_words_due.insert(frame_words_due.size(), fw);
            end
            n += frame_len;
            fill -= frame_len;
            for (int unsigned k = 0; k < fill; k++) fbuf[k] = fbuf[k + frame_len];
            frame_len = 0;
        end
    endtask

    task automatic predict_word(input logic [31:0] w);
        int unsigned n;
        bit held;
        n = 0;
        if (fill > 0) emit_frames(n, held);
        if (fill >= BUF_WORDS) resync();
        if (fill == 0 && w != magic) return;
        fbuf[fill] = w;
        fill++;
        held = 1'b0;
        if (fill >= HEADER_WORDS) emit_frames(n, held);
        if (!held && fill >= BUF_WORDS) resync();
    endtask

    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
        predict_word(w);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (frame_words_due.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_MAGIC_WORD:     magic       = value;
            CFG_END_WORD:       end_w       = value;
            CFG_FORMAT_VERSION: version     = value[15:0];
            CFG_MAP_FLAG_MASK:  map_mask    = value[15:0];
            CFG_MAX_RANGE:      max_range   = value[6:0];
            CFG_MAX_DOPPLER:    max_doppler = value[6:0];
            CFG_MAX_HIT_COUNT:  hit_cap     = value[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_frame(input int nh, input int nr, input int nd, input bit map,
                              input bit bad_end, input logic [15:0] ver);
        logic [15:0] flags;
        int body;
        flags = map ? (16'($urandom) | map_mask) : (16'($urandom) & ~map_mask);
        send_word(magic);
        send_word({ver, flags});
        send_word($urandom);
        send_word({16'(nr), 16'(nd)});
        send_word({16'(nh), 16'($urandom)});
        repeat (3) send_word($urandom);
        body = nh * HIT_WORDS + (map ? nr * nd : 0);
        repeat (body) send_word($urandom);
        send_word(bad_end ? ~end_w : end_w);
    endtask

    task automatic send_random_frame();
        int kind, nh, nr, nd, cap;
        bit map;
        kind = $urandom_range(9);
        cap  = (hit_cap < 5) ? hit_cap : 5;
        nh   = $urandom_range(cap);
        map  = (map_mask != 0) && $urandom_range(1);
        nr   = $urandom_range(1, 3);
        nd   = $urandom_range(1, 3);
        case (kind)
            7: send_frame(nh, nr, nd, map, 1'b0, version ^ 16'($urandom_range(1, 65535)));
            8: send_frame(nh, nr, nd, map, 1'b1, version);
            9: repeat ($urandom_range(1, 6))
                   send_word($urandom_range(1) ? magic : $urandom);
            default: send_frame(nh, nr, nd, map, 1'b0, version);
        endcase
    endtask

    task automatic test_directed();
        write_reg(CFG_MAGIC_WORD, 32'hFFFFFFFF);
        write_reg(CFG_END_WORD, 32'h00000000);
        write_reg(CFG_FORMAT_VERSION, 32'h0000FFFF);
        write_reg(CFG_MAP_FLAG_MASK, 32'h00008000);
        write_reg(CFG_MAX_RANGE, 32'd64);
        write_reg(CFG_MAX_DOPPLER, 32'd64);
        write_reg(CFG_MAX_HIT_COUNT, 32'd64);
        send_word(32'h12345678);
        send_frame(0, 1, 1, 1'b0, 1'b0, version);
        send_frame(1, 2, 3, 1'b1, 1'b0, version);
        send_frame(0, 1, 1, 1'b0, 1'b0, 16'h0000);
        send_frame(0, 0, 4, 1'b1, 1'b0, version);
        send_frame(0, 8, 8, 1'b1, 1'b0, version);
        send_frame(9, 1, 1, 1'b0, 1'b0, version);
        send_frame(0, 1, 1, 1'b0, 1'b1, version);
        wait_idle();
    endtask

    task automatic test_limits();
        write_reg(CFG_MAX_HIT_COUNT, 32'd0);
        write_reg(CFG_MAX_RANGE, 32'd0);
        write_reg(CFG_MAP_FLAG_MASK, 32'h0000FFFF);
        write_reg(CFG_FORMAT_VERSION, 32'h00000000);
        write_reg(CFG_MAGIC_WORD, 32'h00000000);
        write_reg(CFG_END_WORD, 32'hFFFFFFFF);
        send_frame(1, 1, 1, 1'b0, 1'b0, version);
        send_frame(0, 1, 1, 1'b1, 1'b0, version);
        send_frame(0, 1, 1, 1'b0, 1'b0, version);
        wait_idle();
        write_reg(CFG_MAX_RANGE, 32'd1);
        write_reg(CFG_MAX_DOPPLER, 32'd1);
        send_frame(0, 1, 1, 1'b1, 1'b0, version);
        send_frame(0, 1, 2, 1'b1, 1'b0, version);
        wait_idle();
    endtask

    task automatic test_random_phase(input int idle_p, input int stall_p, input int items);
        int start;
        send_idle_pct = idle_p;
        stall_pct     = stall_p;
        write_reg(CFG_MAGIC_WORD, $urandom_range(1) ? 32'hA5A5A5A5 : $urandom);
        write_reg(CFG_END_WORD, $urandom);
        write_reg(CFG_FORMAT_VERSION, $urandom_range(65535));
        write_reg(CFG_MAP_FLAG_MASK, 32'(1) << $urandom_range(15));
        write_reg(CFG_MAX_RANGE, $urandom_range(1, 64));
        write_reg(CFG_MAX_DOPPLER, $urandom_range(1, 64));
        write_reg(CFG_MAX_HIT_COUNT, $urandom_range(1, 64));
        start = sent;
        while (sent - start < items)
        begin
            send_random_frame();
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        fill = 0;
        frame_len = 0;
        magic = '0;
        end_w = '0;
        version = 16'd1;
        map_mask = 16'd1;
        max_range = 7'd64;
        max_doppler = 7'd64;
        hit_cap = 7'd9;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (SETTLE) @(negedge clk);
        test_directed();
        test_limits();
        test_random_phase(0, 0, 45);
        test_random_phase(66, 0, 45);
        test_random_phase(0, 66, 45);
        test_random_phase(27, 27, 45);
        wait_idle();
        if (errors == 0 && frame_words_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
sv/wfdr_pkg.sv
sv/wfdr_cell.sv
sv/word_frame_deframer_resync.sv
dv/word_frame_deframer_resync_tb.sv
